FILE: design/bwts_pkg.sv
// Shared constants of the bilinear wrap texture sampler.
package bwts_pkg;

  localparam int unsigned BWTS_MAX_TEXELS = 65536;
  localparam int unsigned BWTS_FRAC_BITS  = 16;

  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned TADDR_W   = 16;
  localparam int unsigned CHAN_W    = 16;
  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned CCOUNT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OQ_DEPTH  = 4;

  localparam logic [SIZE_W-1:0]   SIZE_MAX   = 17'd65536;
  localparam logic [CCOUNT_W-1:0] CCOUNT_MAX = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

endpackage

FILE: design/bwts_ram.sv
// Generic single-port synchronous RAM with a registered read.
module bwts_ram import bwts_pkg::*; #(
  parameter int unsigned WIDTH = TEXEL_W,
  parameter int unsigned DEPTH = BWTS_MAX_TEXELS
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bilinear_wrap_texture_sampler_core.sv
// Top level of the bilinear wrap texture sampler: address pipeline, fetch sequencer, blend.
//
// This core holds a texture of up to MAX_TEXELS 32-bit texels (four byte channels, channel 0
// in the low byte) in one single-port synchronous RAM, and serves two kinds of input
// transaction in order. A write transaction stores texel_data_i at texel_address_i (wrapped to
// the store size) and produces no output. A sample transaction takes unsigned fixed-point
// coordinates with COORD_FRAC_BITS fraction bits, scales them by the texture width and height,
// wraps the two neighboring integer positions in each direction, fetches the four texels and
// blends them exactly, first along u and then along v, returning each used channel as an 8.8
// fixed-point byte value rounded half up; channels at or above channel_count read as zero.
// Samples pass the sequencer one at a time, since their four texel reads share the single RAM
// port; writes go at one every cycle while no sample holds that port. Up to four results
// queue at the output while the input keeps flowing. Because every RAM access, write or
// read, goes through the same in-order port, a sample always sees every earlier write and
// never a later one. MAX_TEXELS must be a power of
// two. The texture store is not cleared: sampling a texel that was never written returns an
// undefined value. Configuration registers (0 width, 1 height, 2 channel count) may only be
// written while no transaction is in flight.
module bilinear_wrap_texture_sampler_core import bwts_pkg::*; #(
  parameter int unsigned MAX_TEXELS      = BWTS_MAX_TEXELS,
  parameter int unsigned COORD_FRAC_BITS = BWTS_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_wdata_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [TADDR_W-1:0]   texel_address_i,
  input  logic [TEXEL_W-1:0]   texel_data_i,
  input  logic [COORD_W-1:0]   coord_u_i,
  input  logic [COORD_W-1:0]   coord_v_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAN_W-1:0]    channel_0_o,
  output logic [CHAN_W-1:0]    channel_1_o,
  output logic [CHAN_W-1:0]    channel_2_o,
  output logic [CHAN_W-1:0]    channel_3_o
);

  localparam int unsigned F      = COORD_FRAC_BITS;
  localparam int unsigned AW     = $clog2(MAX_TEXELS);
  localparam int unsigned PROD_W = F + SIZE_W;
  localparam int unsigned ROW_W  = F + 8;
  localparam int unsigned ACC_W  = 2 * F + 8;
  localparam int unsigned OQ_AW  = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW  = OQ_AW + 1;
  localparam int unsigned RBW    = 2 * TADDR_W + 1;

  localparam logic [F:0]       ONE   = {1'b1, {F{1'b0}}};
  localparam logic [ACC_W:0]   RND   = (ACC_W + 1)'(1) << (2 * F - 9);
  localparam logic [OQ_CW-1:0] OQ_FULL = OQ_CW'(OQ_DEPTH);

  // ---------------------------------------------------------------------------------------
  // Configuration registers and their effective (clamped) values.
  // ---------------------------------------------------------------------------------------
  logic [SIZE_W-1:0]   width_q, height_q;
  logic [CCOUNT_W-1:0] chan_q;
  logic [SIZE_W-1:0]   tex_w, tex_h;
  logic [CCOUNT_W-1:0] chan_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(1);
      height_q <= SIZE_W'(1);
      chan_q   <= CCOUNT_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEX_WIDTH:     width_q  <= cfg_wdata_i;
        CFG_TEX_HEIGHT:    height_q <= cfg_wdata_i;
        CFG_CHANNEL_COUNT: chan_q   <= cfg_wdata_i[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one, and anything above the largest size acts as that size.
  assign tex_w  = (width_q == '0) ? SIZE_W'(1) : ((width_q > SIZE_MAX) ? SIZE_MAX : width_q);
  assign tex_h  = (height_q == '0) ? SIZE_W'(1) : ((height_q > SIZE_MAX) ? SIZE_MAX : height_q);
  assign chan_n = (chan_q == '0) ? CCOUNT_W'(1) : ((chan_q > CCOUNT_MAX) ? CCOUNT_MAX : chan_q);

  // ---------------------------------------------------------------------------------------
  // Stage 1: scale the coordinate fractions. Since the integer part of a coordinate times the
  // size is a multiple of the size, only the fraction matters for the wrapped position: the
  // product's integer part is already the wrapped index, and its low bits are the blend weight.
  // ---------------------------------------------------------------------------------------
  logic              s1_vld_q, s1_act_q;
  logic [AW-1:0]     s1_addr_q;
  logic [TEXEL_W-1:0] s1_data_q;
  logic [PROD_W-1:0] s1_pu_q, s1_pv_q;
  logic              s1_rdy, s2_rdy, s2_go;

  assign in_ready_o = s1_rdy;
  assign s1_rdy     = !s1_vld_q || s2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_rdy) begin
      s1_act_q  <= action_i;
      s1_addr_q <= AW'(texel_address_i);
      s1_data_q <= texel_data_i;
      s1_pu_q   <= PROD_W'(coord_u_i[F-1:0]) * PROD_W'(tex_w);
      s1_pv_q   <= PROD_W'(coord_v_i[F-1:0]) * PROD_W'(tex_h);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: neighbor indices with wrap, and the store offset of the first row.
  // ---------------------------------------------------------------------------------------
  logic [TADDR_W-1:0] s1_iu0, s1_iv0;
  logic [SIZE_W-1:0]  s1_iu_inc, s1_iv_inc;
  logic [RBW-1:0]     s1_row_prod;

  assign s1_iu0      = s1_pu_q[F +: TADDR_W];
  assign s1_iv0      = s1_pv_q[F +: TADDR_W];
  assign s1_iu_inc   = SIZE_W'(s1_iu0) + SIZE_W'(1);
  assign s1_iv_inc   = SIZE_W'(s1_iv0) + SIZE_W'(1);
  assign s1_row_prod = RBW'(s1_iv0) * RBW'(tex_w);

  logic               s2_vld_q, s2_act_q, s2_vwrap_q;
  logic [AW-1:0]      s2_addr_q, s2_row0_q;
  logic [TEXEL_W-1:0] s2_data_q;
  logic [TADDR_W-1:0] s2_iu0_q, s2_iu1_q;
  logic [F-1:0]       s2_fu_q, s2_fv_q;

  assign s2_rdy = !s2_vld_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && s2_rdy) begin
      s2_act_q   <= s1_act_q;
      s2_addr_q  <= s1_addr_q;
      s2_data_q  <= s1_data_q;
      s2_iu0_q   <= s1_iu0;
      s2_iu1_q   <= (s1_iu_inc == tex_w) ? '0 : s1_iu_inc[TADDR_W-1:0];
      s2_vwrap_q <= (s1_iv_inc == tex_h);
      s2_row0_q  <= s1_row_prod[AW-1:0];
      s2_fu_q    <= s1_pu_q[F-1:0];
      s2_fv_q    <= s1_pv_q[F-1:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Fetch sequencer: owns the RAM port. A write is a single RAM access, a sample four reads in the
  // order top-left, top-right, bottom-left, bottom-right. A sample only starts when the output
  // queue has a slot reserved for its result, so the blend pipeline never has to stall.
  // ---------------------------------------------------------------------------------------
  logic               seq_busy_q, seq_act_q, seq_vwrap_q;
  logic [1:0]         seq_cnt_q;
  logic [AW-1:0]      seq_addr_q, seq_row0_q;
  logic [TEXEL_W-1:0] seq_data_q;
  logic [TADDR_W-1:0] seq_iu0_q, seq_iu1_q;
  logic [F-1:0]       seq_fu_q, seq_fv_q;
  logic               seq_last, seq_free;
  logic [OQ_CW-1:0]   cred_q;

  assign seq_last = seq_busy_q && ((seq_act_q == ACT_WRITE) || (seq_cnt_q == 2'd3));
  assign seq_free = !seq_busy_q || seq_last;
  assign s2_go    = s2_vld_q && seq_free && ((s2_act_q == ACT_WRITE) || (cred_q < OQ_FULL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_busy_q <= 1'b0;
      seq_cnt_q  <= 2'd0;
    end else if (s2_go) begin
      seq_busy_q <= 1'b1;
      seq_cnt_q  <= 2'd0;
    end else if (seq_last) begin
      seq_busy_q <= 1'b0;
      seq_cnt_q  <= 2'd0;
    end else if (seq_busy_q) begin
      seq_cnt_q  <= seq_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      seq_act_q   <= s2_act_q;
      seq_addr_q  <= s2_addr_q;
      seq_data_q  <= s2_data_q;
      seq_iu0_q   <= s2_iu0_q;
      seq_iu1_q   <= s2_iu1_q;
      seq_vwrap_q <= s2_vwrap_q;
      seq_row0_q  <= s2_row0_q;
      seq_fu_q    <= s2_fu_q;
      seq_fv_q    <= s2_fv_q;
    end
  end

  logic [AW-1:0]      row1, iu0_aw, iu1_aw, mem_addr;
  logic               mem_en, mem_we;
  logic [TEXEL_W-1:0] mem_rdata;

  // The bottom row sits one width further on, unless v wrapped back to the first row.
  assign row1   = seq_vwrap_q ? '0 : (seq_row0_q + AW'(tex_w));
  assign iu0_aw = AW'(seq_iu0_q);
  assign iu1_aw = AW'(seq_iu1_q);
  assign mem_en = seq_busy_q;
  assign mem_we = seq_busy_q && (seq_act_q == ACT_WRITE);

  always_comb begin
    if (seq_act_q == ACT_WRITE) begin
      mem_addr = seq_addr_q;
    end else begin
      unique case (seq_cnt_q)
        2'd0: mem_addr = seq_row0_q + iu0_aw;
        2'd1: mem_addr = seq_row0_q + iu1_aw;
        2'd2: mem_addr = row1 + iu0_aw;
        2'd3: mem_addr = row1 + iu1_aw;
      endcase
    end
  end

  bwts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (MAX_TEXELS)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (seq_data_q),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // Read return: collect the first three texels; the fourth goes straight into the blend.
  // The weights are parked while the last read is in flight, since the sequencer may already
  // hold the next transaction by then.
  // ---------------------------------------------------------------------------------------
  logic               rd_vld_q;
  logic [1:0]         rd_cnt_q;
  logic [TEXEL_W-1:0] tex_q [3];
  logic [F-1:0]       pend_fu_q, pend_fv_q;
  logic               b1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_cnt_q <= 2'd0;
    end else begin
      rd_vld_q <= seq_busy_q && (seq_act_q == ACT_SAMPLE);
      rd_cnt_q <= seq_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (rd_cnt_q != 2'd3)) begin
      tex_q[rd_cnt_q] <= mem_rdata;
    end
    if (seq_busy_q && (seq_act_q == ACT_SAMPLE) && (seq_cnt_q == 2'd3)) begin
      pend_fu_q <= seq_fu_q;
      pend_fv_q <= seq_fv_q;
    end
  end

  assign b1_load = rd_vld_q && (rd_cnt_q == 2'd3);

  // ---------------------------------------------------------------------------------------
  // Blend: stage b1 blends along u, stage b2 along v; rounding happens on the way into the
  // output queue.
  // ---------------------------------------------------------------------------------------
  logic       b1_vld_q, b2_vld_q;
  logic [F-1:0] b1_fv_q;
  logic [F:0] omfu, omfv;

  assign omfu = ONE - (F + 1)'(pend_fu_q);
  assign omfv = ONE - (F + 1)'(b1_fv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
    end else begin
      b1_vld_q <= b1_load;
      b2_vld_q <= b1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_load) begin
      b1_fv_q <= pend_fv_q;
    end
  end

  wire [NUM_CHAN-1:0][CHAN_W-1:0] lane_val;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    logic [7:0]       a, b, d, e;
    logic [ROW_W:0]   top_w, bot_w;
    logic [ROW_W-1:0] top_q, bot_q;
    logic [ACC_W:0]   acc_w, rnd_w;
    logic [ACC_W-1:0] acc_q;

    assign a = tex_q[0][8*c +: 8];
    assign b = tex_q[1][8*c +: 8];
    assign d = tex_q[2][8*c +: 8];
    assign e = mem_rdata[8*c +: 8];

    assign top_w = (ROW_W + 1)'(a) * (ROW_W + 1)'(omfu) + (ROW_W + 1)'(b) * (ROW_W + 1)'(pend_fu_q);
    assign bot_w = (ROW_W + 1)'(d) * (ROW_W + 1)'(omfu) + (ROW_W + 1)'(e) * (ROW_W + 1)'(pend_fu_q);
    assign acc_w = (ACC_W + 1)'(top_q) * (ACC_W + 1)'(omfv)
                 + (ACC_W + 1)'(bot_q) * (ACC_W + 1)'(b1_fv_q);
    assign rnd_w = {1'b0, acc_q} + RND;

    always_ff @(posedge clk_i) begin
      if (b1_load) begin
        top_q <= top_w[ROW_W-1:0];
        bot_q <= bot_w[ROW_W-1:0];
      end
      if (b1_vld_q) begin
        acc_q <= acc_w[ACC_W-1:0];
      end
    end

    assign lane_val[c] = (CCOUNT_W'(c) < chan_n) ? rnd_w[2*F-8 +: CHAN_W] : '0;
  end

  // ---------------------------------------------------------------------------------------
  // Output queue. Credits count samples that have left stage 2 and whose results have not
  // yet been taken, so the queue never overflows.
  // ---------------------------------------------------------------------------------------
  logic [NUM_CHAN-1:0][CHAN_W-1:0] oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_CW-1:0] oq_cnt_q;
  logic             oq_push, oq_pop, cred_inc;

  assign oq_push  = b2_vld_q;
  assign oq_pop   = out_valid_o && out_ready_i;
  assign cred_inc = s2_go && (s2_act_q == ACT_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
      cred_q   <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OQ_AW'(1);
      end
      oq_cnt_q <= oq_cnt_q + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
      cred_q   <= cred_q + OQ_CW'(cred_inc) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= lane_val;
    end
  end

  assign out_valid_o = (oq_cnt_q != '0);
  assign channel_0_o = oq_q[oq_rd_q][0];
  assign channel_1_o = oq_q[oq_rd_q][1];
  assign channel_2_o = oq_q[oq_rd_q][2];
  assign channel_3_o = oq_q[oq_rd_q][3];

`ifndef SYNTHESIS
  // Queued results never outnumber the reserved slots.
  a_oq_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= cred_q)
    else $error("output queue holds more results than reserved slots");

  // A finished blend always finds room in the queue.
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_vld_q |-> (oq_cnt_q < OQ_FULL))
    else $error("blend result pushed into a full output queue");

  // A write occupies the RAM port for exactly one cycle.
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_busy_q && (seq_act_q == ACT_WRITE)) |-> (seq_cnt_q == 2'd0))
    else $error("write transaction held the sequencer past its first cycle");

  // The four texel reads of a sample return back to back and in order.
  a_read_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && (rd_cnt_q != 2'd0)) |-> ($past(rd_vld_q) && ($past(rd_cnt_q) == rd_cnt_q - 2'd1)))
    else $error("texel reads of a sample returned out of order");
`endif

endmodule
